@@ rtl/ptd_pkg.sv @@
package ptd_pkg;

    // Number of detector lanes, and the fixed widths of the sample and result words.
    localparam int CHANNELS  = 6;
    localparam int LEVEL_W   = 6;
    localparam int MASK_W    = 6;

    localparam int HOLD_W    = 16;
    localparam int RUN_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
    localparam logic [RUN_W-1:0]  RUN_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT_TICKS   = 2'd0,
        REG_MIN_INTERVAL    = 2'd1,
        REG_MAX_INTERVAL    = 2'd2,
        REG_PULSE_THRESHOLD = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [HOLD_W-1:0] timeout_ticks;
        logic [RUN_W-1:0]  min_interval;
        logic [RUN_W-1:0]  max_interval;
        logic [RUN_W-1:0]  pulse_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        timeout_ticks:   16'd4000,
        min_interval:    8'd4,
        max_interval:    8'd15,
        pulse_threshold: 8'd6
    };

endpackage

@@ rtl/ptd_level_if.sv @@
interface ptd_level_if;
    logic                         valid;
    logic                         ready;
    logic [ptd_pkg::LEVEL_W-1:0]  pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

@@ rtl/ptd_mask_if.sv @@
interface ptd_mask_if;
    logic                        valid;
    logic                        ready;
    logic [ptd_pkg::MASK_W-1:0]  active_mask;

    modport source (output valid, output active_mask, input ready);
    modport sink   (input valid, input active_mask, output ready);
endinterface

@@ rtl/ptd_lane.sv @@
module ptd_lane (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          level,
    input  ptd_pkg::cfg_t cfg,
    output logic          active,
    output logic          active_next
);

    logic                         last_level_reg;
    logic [ptd_pkg::HOLD_W-1:0]   hold_count_reg;
    logic [ptd_pkg::HOLD_W-1:0]   hold_count_next;
    logic [ptd_pkg::RUN_W-1:0]    pulse_run_reg;
    logic [ptd_pkg::RUN_W-1:0]    pulse_run_next;
    logic                         active_reg;

    logic [ptd_pkg::HOLD_W-1:0]   hold_inc;
    logic                         in_window;

    assign hold_inc = (hold_count_reg == ptd_pkg::HOLD_MAX) ? hold_count_reg
                                                            : hold_count_reg + 1'b1;
    assign in_window = (hold_count_reg <= {8'd0, cfg.max_interval}) &&
                       (hold_count_reg >= {8'd0, cfg.min_interval});

    always_comb
    begin
        hold_count_next = hold_count_reg;
        pulse_run_next  = pulse_run_reg;
        active_next     = active_reg;
        if (level == last_level_reg)
        begin
            if (hold_inc > cfg.timeout_ticks)
            begin
                hold_count_next = '0;
                active_next     = 1'b0;
            end
            else
            begin
                hold_count_next = hold_inc;
            end
        end
        else
        begin
            // On an edge the count held so far is the interval since the last edge.
            if (!in_window)
                pulse_run_next = '0;
            else if (pulse_run_reg != ptd_pkg::RUN_MAX)
                pulse_run_next = pulse_run_reg + 1'b1;
            if (pulse_run_next > cfg.pulse_threshold)
                active_next = 1'b1;
            hold_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            hold_count_reg <= '0;
            pulse_run_reg  <= '0;
            active_reg     <= 1'b0;
        end
        else if (accept)
        begin
            last_level_reg <= level;
            hold_count_reg <= hold_count_next;
            pulse_run_reg  <= pulse_run_next;
            active_reg     <= active_next;
        end
    end

    assign active = active_reg;

endmodule

@@ rtl/ptd_merge.sv @@
module ptd_merge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [ptd_pkg::CHANNELS-1:0]   lane_active_next,
    output logic                           take_ready,
    ptd_mask_if.source                     result
);

    logic                          valid_reg;
    logic [ptd_pkg::MASK_W-1:0]    mask_reg;
    logic [ptd_pkg::MASK_W-1:0]    mask_next;

    // Lanes past the mask width are dropped; mask bits without a lane stay clear.
    for (genvar j = 0; j < ptd_pkg::MASK_W; j++)
    begin : g_mask
        if (j < ptd_pkg::CHANNELS)
        begin : g_lane
            assign mask_next[j] = lane_active_next[j];
        end
        else
        begin : g_none
            assign mask_next[j] = 1'b0;
        end
    end

    // A new request may enter when no result is held, or when the held result leaves in the same cycle.
    assign take_ready = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_ready)
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            mask_reg <= mask_next;
    end

    assign result.valid       = valid_reg;
    assign result.active_mask = mask_reg;

endmodule

@@ rtl/ir_pulse_train_detector.sv @@
// An accepted sample tick's active mask is registered and reaches the output in the next cycle.
// Throughput: one tick per cycle; every lane updates its state in the accept cycle.
// The output register holds one result, so a stalled output stops new ticks.
// Reset (rst_n, asynchronous, active low) clears all lane state and the output
// valid, and loads the registers with their default values.
module ir_pulse_train_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    ptd_level_if.sink                        samples,
    ptd_mask_if.source                       result,
    input  logic                             cfg_we,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ptd_pkg::cfg_t                    cfg_reg;
    logic                             accept;
    logic                             take_ready;
    logic [ptd_pkg::CHANNELS-1:0]     lane_active;
    logic [ptd_pkg::CHANNELS-1:0]     lane_active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ptd_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ptd_pkg::cfg_index_t'(cfg_index))
                ptd_pkg::REG_TIMEOUT_TICKS:
                    cfg_reg.timeout_ticks <= cfg_data;
                ptd_pkg::REG_MIN_INTERVAL:
                    cfg_reg.min_interval <= cfg_data[ptd_pkg::RUN_W-1:0];
                ptd_pkg::REG_MAX_INTERVAL:
                    cfg_reg.max_interval <= cfg_data[ptd_pkg::RUN_W-1:0];
                ptd_pkg::REG_PULSE_THRESHOLD:
                    cfg_reg.pulse_threshold <= cfg_data[ptd_pkg::RUN_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign samples.ready = take_ready;
    assign accept        = samples.valid && take_ready;

    for (genvar i = 0; i < ptd_pkg::CHANNELS; i++)
    begin : g_lane
        logic level;
        if (i < ptd_pkg::LEVEL_W)
        begin : g_pin
            assign level = samples.pin_levels[i];
        end
        else
        begin : g_tie
            assign level = 1'b0;
        end

        ptd_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .accept      (accept),
            .level       (level),
            .cfg         (cfg_reg),
            .active      (lane_active[i]),
            .active_next (lane_active_next[i])
        );
    end

    ptd_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .lane_active_next (lane_active_next),
        .take_ready       (take_ready),
        .result           (result)
    );

    // Every accepted tick shows its result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted tick produced no result");

    // The result carries the state that the tick left behind in lane 0.
    a_mask_matches_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (result.active_mask[0] == lane_active[0]))
        else $error("active mask disagrees with lane state");

    // Lane state moves only on an accepted tick.
    a_lanes_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(lane_active))
        else $error("lane state changed without a tick");

    // Input stalls only while a result is waiting at a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (result.valid && !result.ready))
        else $error("input stalled without a blocked result");

endmodule

@@ test/ir_pulse_train_detector_tb.sv @@
module ir_pulse_train_detector_tb;

    import ptd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptd_level_if samples_if ();
    ptd_mask_if  result_if ();

    ir_pulse_train_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predicted lane state and the register values the block should hold.
    cfg_t              det_cfg;
    logic              lane_level [CHANNELS];
    logic [HOLD_W-1:0] lane_hold  [CHANNELS];
    logic [RUN_W-1:0]  lane_run   [CHANNELS];
    logic              lane_on    [CHANNELS];

    logic [MASK_W-1:0]  expected_masks [$];
    logic [MASK_W-1:0]  want_mask;
    logic [LEVEL_W-1:0] last_pins = '0;

    bit quiet = 1'b0;
    int hold_request = 0;
    int mismatch_count = 0;
    int ticks_sent = 0;
    int masks_checked = 0;
    int settings_loaded = 0;
    int cycle_count = 0;

    function automatic logic [MASK_W-1:0] predict_active_mask(input logic [LEVEL_W-1:0] levels);
        logic [MASK_W-1:0] mask;
        logic              lvl;
        mask = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            lvl = (i < LEVEL_W) ? levels[i] : 1'b0;
            if (lvl == lane_level[i])
            begin
                if (lane_hold[i] != HOLD_MAX)
                    lane_hold[i] = lane_hold[i] + 1'b1;
                if (lane_hold[i] > det_cfg.timeout_ticks)
                begin
                    lane_hold[i] = '0;
                    lane_on[i]   = 1'b0;
                end
            end
            else
            begin
                if (lane_hold[i] > HOLD_W'(det_cfg.max_interval) ||
                    lane_hold[i] < HOLD_W'(det_cfg.min_interval))
                    lane_run[i] = '0;
                else if (lane_run[i] != RUN_MAX)
                    lane_run[i] = lane_run[i] + 1'b1;
                if (lane_run[i] > det_cfg.pulse_threshold)
                    lane_on[i] = 1'b1;
                lane_hold[i] = '0;
            end
            lane_level[i] = lvl;
            if (lane_on[i] && i < MASK_W)
                mask[i] = 1'b1;
        end
        return mask;
    endfunction

    function automatic cfg_t make_cfg(input int t, input int mn, input int mx, input int th);
        cfg_t c;
        c.timeout_ticks   = HOLD_W'(t);
        c.min_interval    = RUN_W'(mn);
        c.max_interval    = RUN_W'(mx);
        c.pulse_threshold = RUN_W'(th);
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Offers one sample tick after a random gap (none while quiet) and records its predicted mask on acceptance.
    task automatic send_tick(input logic [LEVEL_W-1:0] levels);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid      <= 1'b1;
        samples_if.pin_levels <= levels;
        do @(posedge clk); while (!samples_if.ready);
        expected_masks.push_back(predict_active_mask(levels));
        last_pins = levels;
        ticks_sent++;
    endtask

    // Toggles the given lanes every period ticks; an empty lane set gives a steady stretch.
    task automatic send_toggles(input logic [LEVEL_W-1:0] lanes, input int period, input int n);
        logic [LEVEL_W-1:0] pins;
        pins = last_pins;
        for (int k = 1; k <= n; k++)
        begin
            if (k % period == 0)
                pins = pins ^ lanes;
            send_tick(pins);
        end
    endtask

    task automatic wait_for_idle();
        samples_if.valid <= 1'b0;
        while (expected_masks.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_data  <= c.timeout_ticks;
        @(posedge clk);
        cfg_index <= REG_MIN_INTERVAL;
        cfg_data  <= CFG_DATA_W'(c.min_interval);
        @(posedge clk);
        cfg_index <= REG_MAX_INTERVAL;
        cfg_data  <= CFG_DATA_W'(c.max_interval);
        @(posedge clk);
        cfg_index <= REG_PULSE_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(c.pulse_threshold);
        @(posedge clk);
        cfg_we  <= 1'b0;
        det_cfg = c;
        settings_loaded++;
    endtask

    task automatic test_default_settings();
        // Edges right after reset come too soon to count as pulses.
        send_tick(6'h00);
        send_tick(6'h3F);
        send_tick(6'h3F);
        send_tick(6'h00);
        send_toggles(6'h3F, 5, 40);
        send_toggles(6'h2A, 16, 48);
        send_toggles(6'h15, 4, 12);
    endtask

    task automatic test_default_timeout();
        // A steady stretch well short of the default timeout leaves active lanes on.
        quiet = 1'b1;
        send_toggles(6'h00, 1, 250);
        quiet = 1'b0;
    endtask

    task automatic test_config_corners();
        // With a timeout of zero, a single steady tick drops an active lane.
        apply_settings(make_cfg(0, 0, 255, 0));
        send_toggles(6'h15, 1, 6);
        send_toggles(6'h00, 1, 3);
        // Minimum above maximum: every edge clears the pulse run.
        apply_settings(make_cfg(200, 5, 3, 0));
        send_toggles(6'h3F, 5, 30);
        // The pulse run stops at its top value, so this threshold is never passed.
        apply_settings(make_cfg(1000, 0, 255, 255));
        send_toggles(6'h3F, 1, 300);
        apply_settings(make_cfg(1000, 0, 255, 254));
        send_toggles(6'h3F, 1, 4);
    endtask

    task automatic test_hold_saturation();
        apply_settings(make_cfg(65535, 0, 255, 0));
        send_toggles(6'h3F, 1, 4);
        // With the largest timeout a steady stretch keeps the lanes active.
        quiet = 1'b1;
        send_toggles(6'h00, 1, 300);
        quiet = 1'b0;
        send_toggles(6'h09, 1, 1);
        send_toggles(6'h00, 1, 3);
    endtask

    task automatic test_output_backpressure();
        apply_settings(make_cfg(40, 2, 9, 3));
        hold_request = 150;
        quiet = 1'b1;
        send_toggles(6'h3F, 4, 60);
        quiet = 1'b0;
    endtask

    task automatic run_random_phase(input cfg_t c, input int n_items);
        int gap_len   [CHANNELS];
        int countdown [CHANNELS];
        int stall_len;
        logic [LEVEL_W-1:0] pins;
        apply_settings(c);
        stall_len = (c.timeout_ticks > 300) ? 300 : int'(c.timeout_ticks) + 3;
        for (int i = 0; i < CHANNELS; i++)
        begin
            gap_len[i]   = $urandom_range(c.min_interval, c.max_interval);
            countdown[i] = $urandom_range(0, gap_len[i]);
        end
        pins = last_pins;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (countdown[i] > 0)
                    countdown[i]--;
                else
                begin
                    pins[i] = ~pins[i];
                    // Mostly intervals inside the window, now and then one from a wider range that may fall outside it.
                    if ($urandom_range(0, 5) == 0)
                        gap_len[i] = $urandom_range(0, int'(c.max_interval) + 3);
                    else
                        gap_len[i] = $urandom_range(c.min_interval, c.max_interval);
                    countdown[i] = ($urandom_range(0, 40) == 0) ? stall_len : gap_len[i];
                end
            end
            if ($urandom_range(0, 15) == 0)
                pins = pins ^ LEVEL_W'($urandom_range(1, 63));
            send_tick(pins);
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_settings();
        int mn;
        run_random_phase(make_cfg(1, 0, 0, 0), 80);
        run_random_phase(make_cfg(65535, 0, 255, 2), 80);
        run_random_phase(make_cfg(30, 9, 3, 1), 80);
        for (int p = 0; p < 5; p++)
        begin
            mn = $urandom_range(0, 10);
            run_random_phase(make_cfg($urandom_range(8, 150), mn, mn + $urandom_range(0, 10),
                                      $urandom_range(0, 8)), 80);
        end
    endtask

    // Result side: a random stall before each request, or a long hold-off when one is asked for.
    initial
    begin
        int w;
        result_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                w = hold_request;
                hold_request = 0;
            end
            else
                w = quiet ? 0 : $urandom_range(0, 10);
            if (w > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && result_if.valid));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_masks.size() == 0)
                report_mismatch($sformatf("active_mask %b with no tick pending",
                                          result_if.active_mask));
            else
            begin
                want_mask = expected_masks.pop_front();
                masks_checked++;
                if (result_if.active_mask !== want_mask)
                    report_mismatch($sformatf("active_mask %b, predicted %b",
                                              result_if.active_mask, want_mask));
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles with %0d masks outstanding.",
                 cycle_count, expected_masks.size());
        $display("[ir_pulse_train_detector] ERROR");
        $finish;
    end

    initial
    begin
        rst_n                 <= 1'b0;
        samples_if.valid      <= 1'b0;
        samples_if.pin_levels <= '0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_TIMEOUT_TICKS;
        cfg_data              <= '0;
        det_cfg = CFG_RESET;
        for (int i = 0; i < CHANNELS; i++)
        begin
            lane_level[i] = 1'b0;
            lane_hold[i]  = '0;
            lane_run[i]   = '0;
            lane_on[i]    = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_settings();
        test_default_timeout();
        test_config_corners();
        test_hold_saturation();
        test_output_backpressure();
        test_random_settings();
        wait_for_idle();

        if (expected_masks.size() != 0)
            report_mismatch($sformatf("%0d predicted masks never arrived", expected_masks.size()));
        $display("Checked %0d active masks from %0d sample ticks under %0d register settings,",
                 masks_checked, ticks_sent, settings_loaded + 1);
        $display("covering timeouts, empty and full interval windows, counter saturation and stalls.");
        if (mismatch_count == 0)
            $display("[ir_pulse_train_detector] OK");
        else
            $display("[ir_pulse_train_detector] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ptd_pkg.sv
rtl/ptd_level_if.sv
rtl/ptd_mask_if.sv
rtl/ptd_lane.sv
rtl/ptd_merge.sv
rtl/ir_pulse_train_detector.sv
test/ir_pulse_train_detector_tb.sv
